[hdl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and types for the HSV to RGB color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W     = 15;
    localparam int FRAC_W    = 9;
    localparam int IDX_W     = 16;
    localparam int STEPS_W   = 13;
    localparam int RGB_W     = 24;
    localparam int CHAN_OUT_W = 8;

    localparam int CHANNEL_BITS_DEF = 8;

    // fixed-point constants
    localparam int HUE_FULL     = 23040;   // 360 degrees in 1/64 degree
    localparam int SECTOR_SPAN  = 3840;    // 60 degrees in 1/64 degree
    localparam int SECTOR_COUNT = 6;
    localparam int UNIT         = 256;     // 1.0 for saturation and brightness
    localparam int NFULL        = 983040;  // SECTOR_SPAN * UNIT

    localparam int REM_W  = 12;            // remainder within a sector
    localparam int N_W    = 20;            // channel factor, up to NFULL
    localparam int NUM_W  = 28;            // palette numerator HUE_FULL * (idx mod steps)

    // 256 * 983040 = 15 * 2^24: shift by 24, then divide by 15 via reciprocal
    localparam int SCALE_SHIFT = 24;
    localparam int RECIP15     = 34953;    // ceil(2^19 / 15)
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 19;

    localparam int LANES = 3;

    typedef enum logic [2:0] {
        SECT_RED_YEL  = 3'd0,
        SECT_YEL_GRN  = 3'd1,
        SECT_GRN_CYN  = 3'd2,
        SECT_CYN_BLU  = 3'd3,
        SECT_BLU_MAG  = 3'd4,
        SECT_MAG_RED  = 3'd5,
        SECT_FULL     = 3'd6
    } sector_t;

    typedef struct packed {
        logic              mode;
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
    } item_t;

endpackage

`default_nettype wire

[hdl/hsv_to_rgb_color.sv]
// hsv_to_rgb_color: an accepted input beat reaches out_valid through the mod divider, quotient divider, hue select,
// products, channel factor, lane and output registers. Throughput one beat per cycle; the whole pipeline holds while
// the output beat stalls. Palette mode runs through a 16-stage mod divider and a 15-stage quotient divider,
// which set the depth; every item takes the same path.
// Reset (rst_n low, async) empties the pipeline and sets hue_steps to 1.
// ----------------------------------------------------------------------------
// hsv_to_rgb_color
// Pipelined HSV to packed 24-bit RGB converter with palette hue generation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_color #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hsv2rgb_pkg::STEPS_W-1:0] cfg_wdata,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic                            req_type,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]   hue_angle,
    input  wire logic [hsv2rgb_pkg::FRAC_W-1:0]  saturation,
    input  wire logic [hsv2rgb_pkg::FRAC_W-1:0]  brightness,
    input  wire logic [hsv2rgb_pkg::IDX_W-1:0]   palette_index,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [hsv2rgb_pkg::RGB_W-1:0]   rgb_color
);

    import hsv2rgb_pkg::*;

    localparam int VN_W = FRAC_W + N_W;
    localparam int X_W  = VN_W + CHANNEL_BITS;
    localparam int Y_W  = X_W - SCALE_SHIFT;
    localparam int Z_W  = Y_W + RECIP_W;

    // ------------------------------------------------------------------
    // configuration and global advance
    // ------------------------------------------------------------------
    logic [STEPS_W-1:0] hue_steps_reg;
    logic [STEPS_W-1:0] steps_eff;
    logic               adv;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_steps_reg <= STEPS_W'(1);
        else if (cfg_we)
            hue_steps_reg <= cfg_wdata;
    end

    // zero steps behaves as one
    assign steps_eff = (hue_steps_reg == '0) ? STEPS_W'(1) : hue_steps_reg;
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;

    // ------------------------------------------------------------------
    // capture and palette index mod steps, one bit per stage
    // ------------------------------------------------------------------
    item_t              md_item_reg  [0:IDX_W];
    logic               md_valid_reg [0:IDX_W];
    logic [STEPS_W-1:0] md_rem_reg   [0:IDX_W];
    logic [IDX_W-1:0]   md_idx_reg   [0:IDX_W];
    logic [STEPS_W-1:0] md_rem_next  [1:IDX_W];
    item_t              cap_item;

    always_comb
    begin
        cap_item.mode = req_type;
        cap_item.hue  = hue_angle;
        cap_item.sat  = (saturation > FRAC_W'(UNIT)) ? FRAC_W'(UNIT) : saturation;
        cap_item.val  = (brightness > FRAC_W'(UNIT)) ? FRAC_W'(UNIT) : brightness;
    end

    always_comb
    begin
        logic [STEPS_W:0] trial;
        for (int i = 1; i <= IDX_W; i++)
        begin
            trial = {md_rem_reg[i-1], md_idx_reg[i-1][IDX_W-1]};
            if (trial >= {1'b0, steps_eff})
                md_rem_next[i] = STEPS_W'(trial - {1'b0, steps_eff});
            else
                md_rem_next[i] = trial[STEPS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            md_item_reg[0] <= cap_item;
            md_rem_reg[0]  <= '0;
            md_idx_reg[0]  <= palette_index;
            for (int i = 1; i <= IDX_W; i++)
            begin
                md_item_reg[i] <= md_item_reg[i-1];
                md_rem_reg[i]  <= md_rem_next[i];
                md_idx_reg[i]  <= {md_idx_reg[i-1][IDX_W-2:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // palette hue = HUE_FULL * rem / steps, one quotient bit per stage
    // ------------------------------------------------------------------
    item_t              dv_item_reg  [0:HUE_W];
    logic               dv_valid_reg [0:HUE_W];
    logic [STEPS_W-1:0] dv_part_reg  [0:HUE_W];
    logic [HUE_W-1:0]   dv_low_reg   [0:HUE_W];
    logic [HUE_W-1:0]   dv_quo_reg   [0:HUE_W];
    logic [STEPS_W-1:0] dv_part_next [1:HUE_W];
    logic               dv_bit_next  [1:HUE_W];
    logic [NUM_W-1:0]   num_next;

    assign num_next = NUM_W'(md_rem_reg[IDX_W]) * NUM_W'(HUE_FULL);

    always_comb
    begin
        logic [STEPS_W:0] trial;
        for (int i = 1; i <= HUE_W; i++)
        begin
            trial = {dv_part_reg[i-1], dv_low_reg[i-1][HUE_W-1]};
            dv_bit_next[i] = (trial >= {1'b0, steps_eff});
            if (dv_bit_next[i])
                dv_part_next[i] = STEPS_W'(trial - {1'b0, steps_eff});
            else
                dv_part_next[i] = trial[STEPS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0] <= md_item_reg[IDX_W];
            // upper numerator bits are already below steps
            dv_part_reg[0] <= num_next[NUM_W-1:HUE_W];
            dv_low_reg[0]  <= num_next[HUE_W-1:0];
            dv_quo_reg[0]  <= '0;
            for (int i = 1; i <= HUE_W; i++)
            begin
                dv_item_reg[i] <= dv_item_reg[i-1];
                dv_part_reg[i] <= dv_part_next[i];
                dv_low_reg[i]  <= {dv_low_reg[i-1][HUE_W-2:0], 1'b0};
                dv_quo_reg[i]  <= {dv_quo_reg[i-1][HUE_W-2:0], dv_bit_next[i]};
            end
        end
    end

    // ------------------------------------------------------------------
    // hue select, clamp, sector and remainder
    // ------------------------------------------------------------------
    logic               hs_valid_reg;
    sector_t            hs_sector_reg;
    logic [REM_W-1:0]   hs_rem_reg;
    logic [FRAC_W-1:0]  hs_sat_reg;
    logic [FRAC_W-1:0]  hs_val_reg;
    sector_t            hs_sector_next;
    logic [REM_W-1:0]   hs_rem_next;
    logic [HUE_W-1:0]   hue_raw;
    logic [HUE_W-1:0]   hue_clamp;
    logic [HUE_W-1:0]   hue_base;
    logic [2:0]         sect_idx;

    always_comb
    begin
        hue_raw   = dv_item_reg[HUE_W].mode ? dv_quo_reg[HUE_W] : dv_item_reg[HUE_W].hue;
        hue_clamp = (hue_raw > HUE_W'(HUE_FULL)) ? HUE_W'(HUE_FULL) : hue_raw;
        sect_idx  = '0;
        hue_base  = '0;
        for (int j = 1; j <= SECTOR_COUNT; j++)
        begin
            if (hue_clamp >= HUE_W'(j * SECTOR_SPAN))
            begin
                sect_idx = 3'(j);
                hue_base = HUE_W'(j * SECTOR_SPAN);
            end
        end
        hs_sector_next = sector_t'(sect_idx);
        hs_rem_next    = REM_W'(hue_clamp - hue_base);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hs_sector_reg <= hs_sector_next;
            hs_rem_reg    <= hs_rem_next;
            hs_sat_reg    <= dv_item_reg[HUE_W].sat;
            hs_val_reg    <= dv_item_reg[HUE_W].val;
        end
    end

    // ------------------------------------------------------------------
    // saturation products
    // ------------------------------------------------------------------
    logic              pr_valid_reg;
    sector_t           pr_sector_reg;
    logic [FRAC_W-1:0] pr_val_reg;
    logic [N_W-1:0]    pr_np_reg;
    logic [N_W-1:0]    pr_sq_reg;
    logic [N_W-1:0]    pr_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_sector_reg <= hs_sector_reg;
            pr_val_reg    <= hs_val_reg;
            pr_np_reg     <= N_W'(SECTOR_SPAN) * N_W'(FRAC_W'(UNIT) - hs_sat_reg);
            pr_sq_reg     <= N_W'(hs_sat_reg) * N_W'(hs_rem_reg);
            pr_st_reg     <= N_W'(hs_sat_reg) * N_W'(REM_W'(SECTOR_SPAN) - hs_rem_reg);
        end
    end

    // ------------------------------------------------------------------
    // channel factors and ordering by sector (lane 0 red, 1 green, 2 blue)
    // ------------------------------------------------------------------
    logic              sl_valid_reg;
    logic [FRAC_W-1:0] sl_val_reg;
    logic [N_W-1:0]    sl_n_reg  [0:LANES-1];
    logic [N_W-1:0]    sl_n_next [0:LANES-1];
    logic [N_W-1:0]    fac_v;
    logic [N_W-1:0]    fac_q;
    logic [N_W-1:0]    fac_t;

    always_comb
    begin
        fac_v = N_W'(NFULL);
        fac_q = N_W'(NFULL) - pr_sq_reg;
        fac_t = N_W'(NFULL) - pr_st_reg;
        case (pr_sector_reg)
            SECT_RED_YEL:
            begin
                sl_n_next[0] = fac_v; sl_n_next[1] = fac_t; sl_n_next[2] = pr_np_reg;
            end
            SECT_YEL_GRN:
            begin
                sl_n_next[0] = fac_q; sl_n_next[1] = fac_v; sl_n_next[2] = pr_np_reg;
            end
            SECT_GRN_CYN:
            begin
                sl_n_next[0] = pr_np_reg; sl_n_next[1] = fac_v; sl_n_next[2] = fac_t;
            end
            SECT_CYN_BLU:
            begin
                sl_n_next[0] = pr_np_reg; sl_n_next[1] = fac_q; sl_n_next[2] = fac_v;
            end
            SECT_BLU_MAG:
            begin
                sl_n_next[0] = fac_t; sl_n_next[1] = pr_np_reg; sl_n_next[2] = fac_v;
            end
            default:
            begin
                // last sector and hue of exactly 360 degrees
                sl_n_next[0] = fac_v; sl_n_next[1] = pr_np_reg; sl_n_next[2] = fac_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_val_reg <= pr_val_reg;
            for (int l = 0; l < LANES; l++)
                sl_n_reg[l] <= sl_n_next[l];
        end
    end

    // ------------------------------------------------------------------
    // channel lanes: brightness * factor, scale by max code, divide by 15 * 2^24
    // ------------------------------------------------------------------
    logic             vn_valid_reg;
    logic             ys_valid_reg;
    logic             zs_valid_reg;
    logic [VN_W-1:0]  vn_reg [0:LANES-1];
    logic [Y_W-1:0]   ys_reg [0:LANES-1];
    logic [Z_W-1:0]   zs_reg [0:LANES-1];
    logic [X_W-1:0]   xs_next [0:LANES-1];
    logic [RGB_W-1:0] rgb_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            xs_next[l] = (X_W'(vn_reg[l]) << CHANNEL_BITS) - X_W'(vn_reg[l]);
        for (int l = 0; l < LANES; l++)
            rgb_next[(LANES-1-l)*CHAN_OUT_W +: CHAN_OUT_W] =
                CHAN_OUT_W'(zs_reg[l] >> RECIP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                vn_reg[l] <= VN_W'(sl_val_reg) * VN_W'(sl_n_reg[l]);
                ys_reg[l] <= xs_next[l][X_W-1:SCALE_SHIFT];
                zs_reg[l] <= Z_W'(ys_reg[l]) * Z_W'(RECIP15);
            end
            rgb_color <= rgb_next;
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= IDX_W; i++)
                md_valid_reg[i] <= 1'b0;
            for (int i = 0; i <= HUE_W; i++)
                dv_valid_reg[i] <= 1'b0;
            hs_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            sl_valid_reg  <= 1'b0;
            vn_valid_reg  <= 1'b0;
            ys_valid_reg  <= 1'b0;
            zs_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            md_valid_reg[0] <= in_valid;
            for (int i = 1; i <= IDX_W; i++)
                md_valid_reg[i] <= md_valid_reg[i-1];
            dv_valid_reg[0] <= md_valid_reg[IDX_W];
            for (int i = 1; i <= HUE_W; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            hs_valid_reg  <= dv_valid_reg[HUE_W];
            pr_valid_reg  <= hs_valid_reg;
            sl_valid_reg  <= pr_valid_reg;
            vn_valid_reg  <= sl_valid_reg;
            ys_valid_reg  <= vn_valid_reg;
            zs_valid_reg  <= ys_valid_reg;
            out_valid_reg <= zs_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
